// ===== sv/scbp_pkg.sv =====
// shared types, constants and the size class function for the buffer pool
`timescale 1ns / 1ps

package scbp_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int MIN_CLASS_DEF   = 5;
    localparam int NUM_HANDLES_DEF = 1024;

    localparam int LEN_W     = 20;
    localparam int HDL_W     = 10;
    localparam int STAT_W    = 3;
    localparam int CLS_OUT_W = 4;
    // wide enough for floor(log2) of a 20-bit length
    localparam int CLS_W     = 5;
    // wide enough to compare any handle against a count of up to 65536
    localparam int CMP_W     = 17;

    typedef enum logic [STAT_W-1:0] {
        ST_REUSED      = 3'd0,
        ST_FRESH       = 3'd1,
        ST_TOO_BIG     = 3'd2,
        ST_NO_HANDLES  = 3'd3,
        ST_BAD_RELEASE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // index of the highest set bit, raised to at least min_c; zero length counts as index 0 before that
    function automatic logic [CLS_W-1:0] class_of(input logic [LEN_W-1:0] len,
                                                  input logic [CLS_W-1:0] min_c);
        logic [CLS_W-1:0] c;
        c = '0;
        for (int i = 1; i < LEN_W; i++) begin
            if (len[i]) begin
                c = CLS_W'(i);
            end
        end
        if (c < min_c) begin
            c = min_c;
        end
        return c;
    endfunction

endpackage

// ===== sv/size_class_buffer_pool.sv =====
// top level: size class decode, two-step read-modify-write sequencer, result register
// result: registered when the EXEC state fires after the accepting edge; a held result stalls it
// a new item is taken only back in S_IDLE, after the read then write back of the
// link and class memories (read in the accept cycle, written when EXEC fires)
// reset: synchronous active low; all free lists empty, handle count zero,
// result register empty; link and class memories are not cleared
`timescale 1ns / 1ps

module size_class_buffer_pool import scbp_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int MIN_CLASS   = MIN_CLASS_DEF,
    parameter int NUM_HANDLES = NUM_HANDLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [HDL_W-1:0]     i_handle,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [HDL_W-1:0]     o_buffer_id,
    output logic [CLS_OUT_W-1:0] o_size_class
);

    localparam int CW = $clog2(NUM_CLASSES);
    localparam int IW = $clog2(NUM_HANDLES);
    localparam int HW = $clog2(NUM_HANDLES + 1);
    localparam logic [HW-1:0] NULL_MARK = HW'(NUM_HANDLES);

    t_state r_state, n_state;

    // captured item
    logic             r_act;
    logic [CLS_W-1:0] r_cls;
    logic             r_big;
    logic [HDL_W-1:0] r_handle;
    logic [HW-1:0]    r_head;
    logic [HW-1:0]    r_fresh, n_fresh;

    // result register
    logic                 r_o_valid, n_o_valid;
    t_status              r_status, n_status;
    logic [HDL_W-1:0]     r_id, n_id;
    logic [CLS_OUT_W-1:0] r_ocls, n_ocls;

    logic             accept, fire;
    logic [CLS_W-1:0] in_cls;
    logic             in_big;

    logic [CW-1:0] head_raddr;
    logic [HW-1:0] head_rdata;
    logic          head_we;
    logic [CW-1:0] head_waddr;
    logic [HW-1:0] head_wdata;

    logic          nl_rd_en;
    logic [HW-1:0] nl_rdata;
    logic          nl_we;
    logic [IW-1:0] nl_waddr;
    logic [HW-1:0] nl_wdata;

    logic          hc_rd_en;
    logic [CW-1:0] hc_rdata;
    logic          hc_we;
    logic [IW-1:0] hc_waddr;
    logic [CW-1:0] hc_wdata;

    logic [CMP_W-1:0] h_wide;
    logic             rel_bad;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign fire    = (r_state == S_EXEC) && (!r_o_valid || i_ready);

    assign in_cls = class_of(i_length, CLS_W'(MIN_CLASS));
    assign in_big = ({1'b0, in_cls} >= (CLS_W+1)'(NUM_CLASSES));

    // head lookup by the request class on accept, by the recorded class on release
    assign head_raddr = (r_state == S_EXEC) ? hc_rdata : in_cls[CW-1:0];

    assign nl_rd_en = accept && (i_action == ACT_ALLOC) && !in_big && (head_rdata < NULL_MARK);
    assign hc_rd_en = accept && (i_action == ACT_RELEASE);

    assign h_wide  = CMP_W'(r_handle);
    assign rel_bad = (h_wide >= CMP_W'(r_fresh)) || (h_wide >= CMP_W'(NUM_HANDLES))
                     || ((CLS_W+1)'(hc_rdata) >= (CLS_W+1)'(NUM_CLASSES));

    always_comb begin
        n_state    = r_state;
        n_fresh    = r_fresh;
        n_o_valid  = r_o_valid;
        n_status   = r_status;
        n_id       = r_id;
        n_ocls     = r_ocls;
        head_we    = 1'b0;
        head_waddr = r_cls[CW-1:0];
        head_wdata = nl_rdata;
        nl_we      = 1'b0;
        nl_waddr   = IW'(r_handle);
        nl_wdata   = head_rdata;
        hc_we      = 1'b0;
        hc_waddr   = r_head[IW-1:0];
        hc_wdata   = r_cls[CW-1:0];

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    if (r_act == ACT_ALLOC) begin
                        if (r_big) begin
                            n_status = ST_TOO_BIG;
                            n_id     = '0;
                            n_ocls   = '0;
                        end else if (r_head < NULL_MARK) begin
                            // pop the list head
                            head_we  = 1'b1;
                            hc_we    = 1'b1;
                            n_status = ST_REUSED;
                            n_id     = HDL_W'(r_head);
                            n_ocls   = CLS_OUT_W'(r_cls);
                        end else if (r_fresh >= NULL_MARK) begin
                            n_status = ST_NO_HANDLES;
                            n_id     = '0;
                            n_ocls   = CLS_OUT_W'(r_cls);
                        end else begin
                            hc_we    = 1'b1;
                            hc_waddr = r_fresh[IW-1:0];
                            n_fresh  = r_fresh + HW'(1);
                            n_status = ST_FRESH;
                            n_id     = HDL_W'(r_fresh);
                            n_ocls   = CLS_OUT_W'(r_cls);
                        end
                    end else begin
                        n_id = r_handle;
                        if (rel_bad) begin
                            n_status = ST_BAD_RELEASE;
                            n_ocls   = '0;
                        end else begin
                            // push onto the list of the recorded class
                            nl_we      = 1'b1;
                            head_we    = 1'b1;
                            head_waddr = hc_rdata;
                            head_wdata = HW'(r_handle);
                            n_status   = ST_REUSED;
                            n_ocls     = CLS_OUT_W'(hc_rdata);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fresh   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fresh   <= n_fresh;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act    <= i_action;
            r_cls    <= in_cls;
            r_big    <= in_big;
            r_handle <= i_handle;
            r_head   <= head_rdata;
        end
        r_status <= n_status;
        r_id     <= n_id;
        r_ocls   <= n_ocls;
    end

    scbp_heads #(
        .NUM_CLASSES(NUM_CLASSES),
        .NUM_HANDLES(NUM_HANDLES)
    ) u_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata)
    );

    // link to the next free handle
    scbp_ram #(
        .DEPTH(NUM_HANDLES),
        .WIDTH(HW)
    ) u_next_link (
        .i_clk   (i_clk),
        .i_rd_en (nl_rd_en),
        .i_raddr (head_rdata[IW-1:0]),
        .o_rdata (nl_rdata),
        .i_we    (nl_we),
        .i_waddr (nl_waddr),
        .i_wdata (nl_wdata)
    );

    // class recorded when a handle is issued
    scbp_ram #(
        .DEPTH(NUM_HANDLES),
        .WIDTH(CW)
    ) u_handle_class (
        .i_clk   (i_clk),
        .i_rd_en (hc_rd_en),
        .i_raddr (IW'(i_handle)),
        .o_rdata (hc_rdata),
        .i_we    (hc_we),
        .i_waddr (hc_waddr),
        .i_wdata (hc_wdata)
    );

    assign o_valid      = r_o_valid;
    assign o_status     = r_status;
    assign o_buffer_id  = r_id;
    assign o_size_class = r_ocls;

endmodule

// ===== sv/scbp_ram.sv =====
// single-port-per-direction synchronous ram with registered read data
`timescale 1ns / 1ps

module scbp_ram import scbp_pkg::*; #(
    parameter int DEPTH = NUM_HANDLES_DEF,
    parameter int WIDTH = CLS_W
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/scbp_heads.sv =====
// free list head per size class, all lists empty after reset
`timescale 1ns / 1ps

module scbp_heads import scbp_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int NUM_HANDLES = NUM_HANDLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(NUM_CLASSES)-1:0]   i_raddr,
    output logic [$clog2(NUM_HANDLES+1)-1:0] o_rdata,
    input  logic                             i_we,
    input  logic [$clog2(NUM_CLASSES)-1:0]   i_waddr,
    input  logic [$clog2(NUM_HANDLES+1)-1:0] i_wdata
);

    localparam int HW = $clog2(NUM_HANDLES + 1);
    localparam logic [HW-1:0] NULL_MARK = HW'(NUM_HANDLES);

    logic [HW-1:0] r_head [NUM_CLASSES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i] <= NULL_MARK;
            end
        end else if (i_we) begin
            r_head[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_head[i_raddr];

endmodule

// ===== sv/scbp_checker.sv =====
// port-level checks for the buffer pool and the bind that attaches them
`timescale 1ns / 1ps

module scbp_checker import scbp_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [STAT_W-1:0]    o_status,
    input logic [HDL_W-1:0]     o_buffer_id,
    input logic [CLS_OUT_W-1:0] o_size_class
);

    // one item in flight: no second transfer right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken on the cycle after a transfer");

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
                                   && $stable(o_buffer_id) && $stable(o_size_class)))
        else $error("stalled result changed");

    a_too_big_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_TOO_BIG)) |-> (o_buffer_id == '0 && o_size_class == '0))
        else $error("too big result carries a handle or class");

    a_bad_rel_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BAD_RELEASE)) |-> (o_size_class == '0))
        else $error("bad release result carries a class");

endmodule

bind size_class_buffer_pool scbp_checker u_scbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_buffer_id  (o_buffer_id),
    .o_size_class (o_size_class)
);
